>>> hdl/tmics_pkg.sv
`default_nettype none
package tmics_pkg;

	localparam int MaxWidthDefault = 1024;
	localparam int CellW = 8;
	localparam int CoordW = 10;
	localparam int CfgDataW = 11;
	localparam int CfgIndexW = 2;

	localparam logic [CfgDataW-1:0] MapWidthReset = 11'd1024;
	localparam logic [CfgDataW-1:0] MapHeightReset = 11'd1024;
	localparam logic SmoothEnReset = 1'b1;
	localparam logic [CfgDataW-1:0] MinHeight = 11'd2;
	localparam logic [CfgDataW-1:0] MaxHeight = 11'd1024;

	typedef enum logic [CfgIndexW-1:0] {
		REG_MAP_WIDTH = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_SMOOTH_EN = 2'd2
	} reg_index_t;

	// center and neighbor values read from the line buffers for one cell
	typedef struct packed {
		logic [CellW-1:0] b;
		logic [CellW-1:0] right;
		logic [CellW-1:0] up;
	} line_rd_t;

	typedef struct packed {
		logic take;
		logic smooth_we;
	} line_ctrl_t;

	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CellW-1:0] value;
		logic frame_done;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/tmics_if.sv
`default_nettype none
interface tmics_cell_if;
	logic valid;
	logic ready;
	logic [tmics_pkg::CellW-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

interface tmics_result_if;
	logic valid;
	logic ready;
	logic [tmics_pkg::CoordW-1:0] out_x;
	logic [tmics_pkg::CoordW-1:0] out_y;
	logic [tmics_pkg::CellW-1:0] out_value;
	logic frame_done;

	modport source (output valid, output out_x, output out_y, output out_value,
		output frame_done, input ready);
	modport sink (input valid, input out_x, input out_y, input out_value,
		input frame_done, output ready);
endinterface

interface tmics_cfg_if;
	logic valid;
	logic ready;
	logic [tmics_pkg::CfgIndexW-1:0] index;
	logic [tmics_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/terrain_map_isolated_cell_smoothing_unit.sv
`default_nettype none
// Streaming isolated-cell smoother for a byte terrain map in raster order. One cell is
// accepted per cycle unless stage 1 stalls; each cell of row r gives the finished cell of
// row r-1 at the same column through the stage 1 and output registers, so the first row of
// a frame gives no result and a row's results trail it by one row. During the last row each
// cell gives two results (the cell above, then the cell itself), so there the result port
// sets the pace. The originals and smoothed values of the previous row sit in two line
// memories of MAX_WIDTH bytes, read at the column of the incoming cell (and the column to
// its right) as the cell is taken; not cleared after reset, they need no clearing pass.
module terrain_map_isolated_cell_smoothing_unit #(
	parameter int MAX_WIDTH = tmics_pkg::MaxWidthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	tmics_cell_if.sink map_cell,
	tmics_result_if.source result,
	tmics_cfg_if.sink cfg
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CW = (XW + 1 > tmics_pkg::CfgDataW) ? XW + 1 : tmics_pkg::CfgDataW;
	localparam int HW = tmics_pkg::CfgDataW;
	localparam int YW = tmics_pkg::CoordW;
	localparam int VW = tmics_pkg::CellW;

	logic [HW-1:0] map_width_q;
	logic [HW-1:0] map_height_q;
	logic smooth_en_q;

	logic [CW-1:0] mw;
	logic [CW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [CW-1:0] col_ext;
	logic [HW-1:0] row_inc;
	logic last_col;
	logic last_row;
	logic interior_in;
	logic accept;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	logic s1_valid_q;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] row_s1;
	logic [VW-1:0] v_s1;
	logic last_col_s1;
	logic last_row_s1;
	logic interior_s1;
	logic has_up_s1;

	logic [VW-1:0] left_q;
	logic [VW-1:0] val;
	tmics_pkg::line_rd_t rd;
	tmics_pkg::line_ctrl_t line_ctrl;

	tmics_pkg::result_t first_res;
	tmics_pkg::result_t second_res;
	tmics_pkg::result_t out_q;
	tmics_pkg::result_t sec_q;
	logic out_valid_q;
	logic sec_valid_q;
	logic out_free;
	logic out_xfer;
	logic s1_adv;
	logic emit;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= tmics_pkg::MapWidthReset;
			map_height_q <= tmics_pkg::MapHeightReset;
			smooth_en_q <= tmics_pkg::SmoothEnReset;
		end else if (cfg.valid) begin
			case (tmics_pkg::reg_index_t'(cfg.index))
				tmics_pkg::REG_MAP_WIDTH: map_width_q <= cfg.data;
				tmics_pkg::REG_MAP_HEIGHT: map_height_q <= cfg.data;
				tmics_pkg::REG_SMOOTH_EN: smooth_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// clamp bounds
	always_comb begin
		mw = CW'(map_width_q);
		if (mw == '0) begin
			eff_w = CW'(1);
		end else if (mw > CW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = mw;
		end
		if (map_height_q < tmics_pkg::MinHeight) begin
			eff_h = tmics_pkg::MinHeight;
		end else if (map_height_q > tmics_pkg::MaxHeight) begin
			eff_h = tmics_pkg::MaxHeight;
		end else begin
			eff_h = map_height_q;
		end
	end

	assign col_ext = CW'(col_q);
	assign row_inc = HW'(row_q) + HW'(1);
	assign last_col = (col_ext + CW'(1)) >= eff_w;
	assign last_row = row_inc >= eff_h;
	assign interior_in = smooth_en_q && (col_q != '0) && ((col_ext + CW'(2)) <= eff_w)
		&& (row_q >= YW'(2)) && (row_inc <= eff_h);

	assign accept = map_cell.valid && map_cell.ready;

	// raster position of the next input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : YW'(row_inc);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	assign line_ctrl = '{take: accept, smooth_we: emit};

	tmics_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.ctrl(line_ctrl),
		.addr(col_q),
		.orig_wdata(map_cell.cell_value),
		.smooth_addr(x_s1),
		.smooth_wdata(val),
		.rd(rd)
	);

	// stage 1: registered cell, line reads arrive alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= col_q;
			row_s1 <= row_q;
			v_s1 <= map_cell.cell_value;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			interior_s1 <= interior_in;
			has_up_s1 <= (row_q != '0);
		end
	end

	tmics_cell_eval u_cell_eval (
		.rd(rd),
		.left(left_q),
		.down(v_s1),
		.interior(interior_s1),
		.value(val)
	);

	always_comb begin
		first_res.x = YW'(x_s1);
		first_res.y = row_s1 - YW'(1);
		first_res.value = val;
		first_res.frame_done = 1'b0;
		second_res.x = YW'(x_s1);
		second_res.y = row_s1;
		second_res.value = v_s1;
		second_res.frame_done = last_col_s1;
	end

	// output register plus a second slot for the last-row pair
	assign out_xfer = out_valid_q && result.ready;
	assign out_free = !out_valid_q || (result.ready && !sec_valid_q);
	assign s1_adv = s1_valid_q && (!has_up_s1 || out_free);
	assign emit = s1_adv && has_up_s1;
	assign map_cell.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
			left_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= last_row_s1;
				left_q <= val;
			end else if (out_xfer) begin
				out_valid_q <= sec_valid_q;
				sec_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= first_res;
			sec_q <= second_res;
		end else if (out_xfer && sec_valid_q) begin
			out_q <= sec_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_x = out_q.x;
	assign result.out_y = out_q.y;
	assign result.out_value = out_q.value;
	assign result.frame_done = out_q.frame_done;

	a_sec_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> out_valid_q)
		else $error("second result slot full with output register empty");

	a_pair_match: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> (out_q.x == sec_q.x) && (out_q.y + YW'(1) == sec_q.y))
		else $error("last-row result pair does not share a column and adjacent rows");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(x_s1) && $stable(v_s1))
		else $error("stalled stage 1 cell lost or changed");

endmodule
`default_nettype wire

>>> hdl/tmics_line_buf.sv
`default_nettype none
module tmics_line_buf #(
	parameter int MAX_WIDTH = tmics_pkg::MaxWidthDefault
) (
	input wire logic clk,
	input wire tmics_pkg::line_ctrl_t ctrl,
	input wire logic [$clog2(MAX_WIDTH)-1:0] addr,
	input wire logic [tmics_pkg::CellW-1:0] orig_wdata,
	input wire logic [$clog2(MAX_WIDTH)-1:0] smooth_addr,
	input wire logic [tmics_pkg::CellW-1:0] smooth_wdata,
	output tmics_pkg::line_rd_t rd
);
	localparam int AW = $clog2(MAX_WIDTH);

	logic [tmics_pkg::CellW-1:0] orig_mem [MAX_WIDTH];
	logic [tmics_pkg::CellW-1:0] smooth_mem [MAX_WIDTH];
	logic [AW-1:0] right_addr;

	assign right_addr = addr + AW'(1);

	// read before write: the cell of the row above comes out while the new one goes in
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			rd.b <= orig_mem[addr];
			rd.right <= orig_mem[right_addr];
			rd.up <= smooth_mem[addr];
			orig_mem[addr] <= orig_wdata;
		end
		if (ctrl.smooth_we) begin
			smooth_mem[smooth_addr] <= smooth_wdata;
		end
	end
endmodule
`default_nettype wire

>>> hdl/tmics_cell_eval.sv
`default_nettype none
module tmics_cell_eval (
	input wire tmics_pkg::line_rd_t rd,
	input wire logic [tmics_pkg::CellW-1:0] left,
	input wire logic [tmics_pkg::CellW-1:0] down,
	input wire logic interior,
	output logic [tmics_pkg::CellW-1:0] value
);
	logic [tmics_pkg::CellW-1:0] nb [4];
	logic [2:0] same;
	logic [2:0] lo;
	logic [2:0] hi;

	always_comb begin
		nb[0] = left;
		nb[1] = rd.right;
		nb[2] = rd.up;
		nb[3] = down;
		same = '0;
		lo = '0;
		hi = '0;
		for (int i = 0; i < 4; i++) begin
			if (nb[i] == rd.b) begin
				same = same + 3'd1;
			end else if (nb[i] < rd.b) begin
				lo = lo + 3'd1;
			end else begin
				hi = hi + 3'd1;
			end
		end
		// with no equal neighbor all four differ, so some count is nonzero
		value = rd.b;
		if (interior && same == 3'd0) begin
			if (hi > lo) begin
				value = rd.b + 8'd1;
			end else begin
				value = rd.b - 8'd1;
			end
		end
	end
endmodule
`default_nettype wire
